// File: hw/rtl/ipv4_range_table_lookup_defines.svh
// ----------------------------------------------------------------------------
// ipv4 range table lookup assertion macros
// shared property wrappers for the lookup block, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef IPV4_RANGE_TABLE_LOOKUP_DEFINES_SVH
`define IPV4_RANGE_TABLE_LOOKUP_DEFINES_SVH

// same-cycle implication
`define IPRTL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iprtl assertion failed");

// next-cycle implication
`define IPRTL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iprtl assertion failed");

`endif

// File: hw/rtl/iprtl_pkg.sv
// ----------------------------------------------------------------------------
// iprtl_pkg
// shared types and constants for the ipv4 range table lookup block
// ----------------------------------------------------------------------------
package iprtl_pkg;

    localparam int ENTRIES = 65536;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = 17;
    localparam int IP_W    = 32;
    localparam int OFF_W   = 24;
    localparam int LEN_W   = 8;
    localparam int ADDR_W  = 25;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        CMD_WR_OCTET = 2'd0,
        CMD_WR_RANGE = 2'd1,
        CMD_LOOKUP   = 2'd2
    } t_command;

    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_TEXT_BASE   = 1'b1;

    typedef struct packed {
        logic [IP_W-1:0]  end_ip;
        logic [OFF_W-1:0] offset;
        logic [LEN_W-1:0] length;
    } t_range;

    typedef struct packed {
        logic wr_oct;
        logic wr_rng;
        logic load_ip;
        logic start;
        logic step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic cont;
    } t_stat;

endpackage

// File: hw/rtl/ipv4_range_table_lookup.sv
// ----------------------------------------------------------------------------
// ipv4_range_table_lookup
// first-octet start table plus sorted range table, lower-bound binary search
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_stall   i_command .. i_lookup_ip
// output    out        o_out_valid / i_out_stall o_status .. o_record_length
// config    in         psel penable pwrite       paddr pwdata prdata
//
// a table write is done as it is accepted; a lookup reads the octet start table, then
// halves the range search over up to 65536 entries through the range table read port
// reset clears the sequencer, output valid and both config registers
// table contents are undefined until written
// a finished result waits in the output register under stall while the next
// item is taken; a second lookup then holds in its last cycle until it drains
// ----------------------------------------------------------------------------
module ipv4_range_table_lookup (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_command,
    input  logic [15:0]                      i_table_index,
    input  logic [iprtl_pkg::CNT_W-1:0]      i_first_entry,
    input  logic [iprtl_pkg::IP_W-1:0]       i_range_end_ip,
    input  logic [iprtl_pkg::OFF_W-1:0]      i_record_offset_in,
    input  logic [iprtl_pkg::LEN_W-1:0]      i_record_length_in,
    input  logic [iprtl_pkg::IP_W-1:0]       i_lookup_ip,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_status,
    output logic [iprtl_pkg::CNT_W-1:0]      o_matched_entry,
    output logic [iprtl_pkg::ADDR_W-1:0]     o_record_address,
    output logic [iprtl_pkg::LEN_W-1:0]      o_record_length,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [iprtl_pkg::PADDR_W-1:0]    paddr,
    input  logic [iprtl_pkg::PDATA_W-1:0]    pwdata,
    output logic [iprtl_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready
);

    iprtl_pkg::t_cmd  w_cmd;
    iprtl_pkg::t_stat w_stat;

    assign pready = 1'b1;

    iprtl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    iprtl_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_table_index      (i_table_index),
        .i_first_entry      (i_first_entry),
        .i_range_end_ip     (i_range_end_ip),
        .i_record_offset_in (i_record_offset_in),
        .i_record_length_in (i_record_length_in),
        .i_lookup_ip        (i_lookup_ip),
        .i_psel             (psel),
        .i_penable          (penable),
        .i_pwrite           (pwrite),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .o_prdata           (prdata),
        .o_status           (o_status),
        .o_matched_entry    (o_matched_entry),
        .o_record_address   (o_record_address),
        .o_record_length    (o_record_length)
    );

endmodule

// File: hw/rtl/iprtl_dpath.sv
// ----------------------------------------------------------------------------
// iprtl_dpath
// table memories, config registers, binary search bounds and result register
// ----------------------------------------------------------------------------
module iprtl_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  iprtl_pkg::t_cmd                  i_cmd,
    output iprtl_pkg::t_stat                 o_stat,
    input  logic [15:0]                      i_table_index,
    input  logic [iprtl_pkg::CNT_W-1:0]      i_first_entry,
    input  logic [iprtl_pkg::IP_W-1:0]       i_range_end_ip,
    input  logic [iprtl_pkg::OFF_W-1:0]      i_record_offset_in,
    input  logic [iprtl_pkg::LEN_W-1:0]      i_record_length_in,
    input  logic [iprtl_pkg::IP_W-1:0]       i_lookup_ip,
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic [iprtl_pkg::PADDR_W-1:0]    i_paddr,
    input  logic [iprtl_pkg::PDATA_W-1:0]    i_pwdata,
    output logic [iprtl_pkg::PDATA_W-1:0]    o_prdata,
    output logic                             o_status,
    output logic [iprtl_pkg::CNT_W-1:0]      o_matched_entry,
    output logic [iprtl_pkg::ADDR_W-1:0]     o_record_address,
    output logic [iprtl_pkg::LEN_W-1:0]      o_record_length
);

    logic [iprtl_pkg::CNT_W-1:0]  r_oct_mem [256];
    iprtl_pkg::t_range            r_rng_mem [iprtl_pkg::ENTRIES];

    logic [iprtl_pkg::CNT_W-1:0]  r_entry_count;
    logic [iprtl_pkg::OFF_W-1:0]  r_text_base;
    logic [iprtl_pkg::IP_W-1:0]   r_ip;
    logic [iprtl_pkg::CNT_W-1:0]  r_oct_q;
    iprtl_pkg::t_range            r_rng_q;
    logic [iprtl_pkg::CNT_W-1:0]  r_lo;
    logic [iprtl_pkg::CNT_W-1:0]  r_hi;
    logic [iprtl_pkg::CNT_W-1:0]  r_mid;
    logic                         r_status;
    logic [iprtl_pkg::CNT_W-1:0]  r_matched;
    logic [iprtl_pkg::ADDR_W-1:0] r_addr;
    logic [iprtl_pkg::LEN_W-1:0]  r_len;

    logic [iprtl_pkg::CNT_W-1:0]  w_bound;
    logic [iprtl_pkg::CNT_W-1:0]  w_lo;
    logic [iprtl_pkg::CNT_W-1:0]  w_hi;
    logic [iprtl_pkg::CNT_W-1:0]  w_mid;
    logic                         w_cfg_wr;
    logic                         w_rng_ok;
    logic                         w_past_end;

    assign w_cfg_wr = i_psel && i_penable && i_pwrite;
    assign w_rng_ok = {1'b0, i_table_index} < iprtl_pkg::CNT_W'(iprtl_pkg::ENTRIES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_text_base   <= '0;
        end else if (w_cfg_wr) begin
            if (i_paddr[2] == iprtl_pkg::REG_ENTRY_COUNT) begin
                r_entry_count <= i_pwdata[iprtl_pkg::CNT_W-1:0];
            end else begin
                r_text_base <= i_pwdata[iprtl_pkg::OFF_W-1:0];
            end
        end
    end

    assign o_prdata = (i_paddr[2] == iprtl_pkg::REG_ENTRY_COUNT) ?
                      iprtl_pkg::PDATA_W'(r_entry_count) :
                      iprtl_pkg::PDATA_W'(r_text_base);

    // octet start table
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_oct && (i_table_index[15:8] == 8'd0)) begin
            r_oct_mem[i_table_index[7:0]] <= i_first_entry;
        end
        if (i_cmd.load_ip) begin
            r_oct_q <= r_oct_mem[i_lookup_ip[31:24]];
            r_ip    <= i_lookup_ip;
        end
    end

    assign w_bound = (r_entry_count > iprtl_pkg::CNT_W'(iprtl_pkg::ENTRIES)) ?
                     iprtl_pkg::CNT_W'(iprtl_pkg::ENTRIES) : r_entry_count;

    // one halving step per cycle
    always_comb begin
        if (i_cmd.start) begin
            w_lo = r_oct_q;
            w_hi = w_bound;
        end else if (r_rng_q.end_ip < r_ip) begin
            w_lo = r_mid + iprtl_pkg::CNT_W'(1);
            w_hi = r_hi;
        end else begin
            w_lo = r_lo;
            w_hi = r_mid;
        end
        w_mid       = w_lo + ((w_hi - w_lo) >> 1);
        o_stat.cont = w_lo < w_hi;
    end

    // range table, read address is the next probe (the final entry once lo meets hi)
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_rng && w_rng_ok) begin
            r_rng_mem[iprtl_pkg::IDX_W'(i_table_index)] <=
                {i_range_end_ip, i_record_offset_in, i_record_length_in};
        end
        if (i_cmd.step) begin
            r_rng_q <= r_rng_mem[iprtl_pkg::IDX_W'(w_mid)];
            r_lo    <= w_lo;
            r_hi    <= w_hi;
            r_mid   <= w_mid;
        end
    end

    assign w_past_end = r_lo >= w_bound;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status  <= w_past_end;
            r_matched <= r_lo;
            if (w_past_end) begin
                r_addr <= '0;
                r_len  <= '0;
            end else begin
                r_addr <= {1'b0, r_text_base} + {1'b0, r_rng_q.offset};
                r_len  <= r_rng_q.length;
            end
        end
    end

    assign o_status         = r_status;
    assign o_matched_entry  = r_matched;
    assign o_record_address = r_addr;
    assign o_record_length  = r_len;

endmodule

// File: hw/rtl/iprtl_ctrl.sv
// ----------------------------------------------------------------------------
// iprtl_ctrl
// sequencer for table writes and lookups, owns the input and output handshakes
// ----------------------------------------------------------------------------
`include "ipv4_range_table_lookup_defines.svh"

module iprtl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_command,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output iprtl_pkg::t_cmd  o_cmd,
    input  iprtl_pkg::t_stat i_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_SEARCH,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_out_free;

    always_comb begin
        w_accept       = i_in_valid && (r_state == S_IDLE);
        w_out_free     = !r_out_valid || !i_out_stall;
        o_cmd.wr_oct   = w_accept && (i_command == iprtl_pkg::CMD_WR_OCTET);
        o_cmd.wr_rng   = w_accept && (i_command == iprtl_pkg::CMD_WR_RANGE);
        o_cmd.load_ip  = w_accept && (i_command == iprtl_pkg::CMD_LOOKUP);
        o_cmd.start    = r_state == S_START;
        o_cmd.step     = (r_state == S_START) || (r_state == S_SEARCH);
        o_cmd.load_out = (r_state == S_FINISH) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.load_ip) begin
                        r_state <= S_START;
                    end
                end
                S_START, S_SEARCH: begin
                    r_state <= i_stat.cont ? S_SEARCH : S_FINISH;
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

    `IPRTL_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, o_cmd.load_out, !r_out_valid || !i_out_stall)
    `IPRTL_ASSERT_NXT(a_lookup_starts, i_clk, i_rst_n, o_cmd.load_ip, r_state == S_START)
    `IPRTL_ASSERT_NXT(a_search_ends, i_clk, i_rst_n, o_cmd.step && !i_stat.cont, r_state == S_FINISH)
    `IPRTL_ASSERT_IMP(a_result_source, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_FINISH))

endmodule
